FILE: rtl/core/assert_macros.svh
// assertion macros used by the sequencer fta_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables the check
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset disables the check
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/fta_pkg.sv
// types, constants and codes of the fixed timestep accumulator
package fta_pkg;

   localparam int STEP_LIMIT      = 60;
   localparam int TIME_FRAC_BITS  = 20;
   localparam int ALPHA_BITS      = 16;
   localparam int SCALE_FRAC_BITS = 12;

   localparam int FIXED_STEP_W = 21;
   localparam int TIME_SCALE_W = 17;
   localparam int MAX_STEPS_W  = 6;
   localparam int CSR_DATA_W   = 21;
   localparam int CSR_INDEX_W  = 2;
   localparam int DELTA_W      = 32;
   localparam int ACC_W        = 38;
   localparam int SUM_W        = 48;
   localparam int COUNT_W      = 32;
   localparam int PRODUCT_W    = DELTA_W + TIME_SCALE_W;
   localparam int DIV_CNT_W    = $clog2(ALPHA_BITS);

   localparam logic [FIXED_STEP_W-1:0] STEP_MIN =
      FIXED_STEP_W'(((64'd1 << TIME_FRAC_BITS) + 64'd999) / 64'd1000);
   localparam logic [FIXED_STEP_W-1:0] STEP_MAX = FIXED_STEP_W'(64'd1 << TIME_FRAC_BITS);
   localparam logic [TIME_SCALE_W-1:0] SCALE_MAX =
      TIME_SCALE_W'(64'd16 << SCALE_FRAC_BITS);
   localparam logic [MAX_STEPS_W-1:0]  STEPS_MAX = MAX_STEPS_W'(STEP_LIMIT);

   localparam logic [FIXED_STEP_W-1:0] FIXED_STEP_RESET = FIXED_STEP_W'(17476);
   localparam logic [TIME_SCALE_W-1:0] TIME_SCALE_RESET = TIME_SCALE_W'(4096);
   localparam logic [MAX_STEPS_W-1:0]  MAX_STEPS_RESET  = MAX_STEPS_W'(5);

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ALPHA_BITS - 1);

   typedef enum logic [1:0] {
      OP_FRAME    = 2'd0,
      OP_SINGLE   = 2'd1,
      OP_CONSUMED = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIXED_STEP = 2'd0,
      CSR_TIME_SCALE = 2'd1,
      CSR_MAX_STEPS  = 2'd2,
      CSR_PAUSED     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_ADD,
      ST_SUB,
      ST_DIV_INIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [DELTA_W-1:0] frame_delta;
   } req_payload_type;

   typedef struct packed {
      logic [MAX_STEPS_W-1:0] step_count;
      logic                   clamped;
      logic [ALPHA_BITS-1:0]  alpha;
      logic [SUM_W-1:0]       real_time;
      logic [SUM_W-1:0]       game_time;
      logic [COUNT_W-1:0]     tick_total;
      logic [COUNT_W-1:0]     clamp_total;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic add;
      logic sub;
      logic clamp;
      logic div_init;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic run_frame;
      logic acc_ge_step;
      logic below_max;
   } status_type;

endpackage

FILE: rtl/core/fta_ctrl.sv
// sequencer of the fixed timestep accumulator
`include "assert_macros.svh"

module fta_ctrl
   import fta_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = status.run_frame ? ST_ADD : ST_DIV_INIT;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            if (status.acc_ge_step && status.below_max) begin
               cmd.sub = 1'b1;
            end else begin
               cmd.clamp = status.acc_ge_step;
               state_in  = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            div_cnt_in   = '0;
            state_in     = status.acc_ge_step ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE), "result raised outside done")
   `ASSERT_NEXT(a_no_overwrite, clock, reset, (state_ff == ST_DONE) && rsp_valid_ff && rsp_stall, state_ff == ST_DONE, "waiting result overwritten")
   `ASSERT_NEXT(a_div_length, clock, reset, (state_ff == ST_DIV) && (div_cnt_ff == DIV_LAST), state_ff == ST_DONE, "division overran")

endmodule

FILE: rtl/core/fta_dp.sv
// datapath of the fixed timestep accumulator: registers, state and alpha divider
module fta_dp
   import fta_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  req_payload_type        req_payload,
   input  cmd_type                cmd,
   output status_type             status,
   output rsp_payload_type        rsp_payload
);

   // configuration
   logic [FIXED_STEP_W-1:0] fixed_step_ff;
   logic [TIME_SCALE_W-1:0] time_scale_ff;
   logic [MAX_STEPS_W-1:0]  max_steps_ff;
   logic                    paused_ff;

   // architectural state
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               pending_ff;
   logic [SUM_W-1:0]   real_sum_ff;
   logic [SUM_W-1:0]   game_sum_ff;
   logic [COUNT_W-1:0] tick_ff;
   logic [COUNT_W-1:0] clamp_cnt_ff;

   // per-request working registers
   logic [1:0]              op_ff;
   logic [DELTA_W-1:0]      delta_ff;
   logic [PRODUCT_W-1:0]    product_ff;
   logic [MAX_STEPS_W-1:0]  steps_ff;
   logic                    clamped_ff;
   logic [FIXED_STEP_W-1:0] rem_ff;
   logic [ALPHA_BITS-1:0]   quot_ff;
   rsp_payload_type         out_ff;

   logic [PRODUCT_W-SCALE_FRAC_BITS-1:0] scaled;
   logic [FIXED_STEP_W:0]                rem_dbl;
   logic                                 rem_ge;

   assign scaled  = product_ff[PRODUCT_W-1:SCALE_FRAC_BITS];
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_ge  = (rem_dbl >= {1'b0, fixed_step_ff});

   assign status.run_frame   = (op_ff == OP_FRAME) && !paused_ff;
   assign status.acc_ge_step = (acc_ff >= ACC_W'(fixed_step_ff));
   assign status.below_max   = (steps_ff < max_steps_ff);

   // configuration writes, saturated to range
   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_step_ff <= FIXED_STEP_RESET;
         time_scale_ff <= TIME_SCALE_RESET;
         max_steps_ff  <= MAX_STEPS_RESET;
         paused_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIXED_STEP: begin
               if (csr_wdata < STEP_MIN)      fixed_step_ff <= STEP_MIN;
               else if (csr_wdata > STEP_MAX) fixed_step_ff <= STEP_MAX;
               else                           fixed_step_ff <= csr_wdata;
            end
            CSR_TIME_SCALE: begin
               if (csr_wdata > CSR_DATA_W'(SCALE_MAX)) time_scale_ff <= SCALE_MAX;
               else time_scale_ff <= csr_wdata[TIME_SCALE_W-1:0];
            end
            CSR_MAX_STEPS: begin
               if (csr_wdata == '0) max_steps_ff <= MAX_STEPS_W'(1);
               else if (csr_wdata > CSR_DATA_W'(STEPS_MAX)) max_steps_ff <= STEPS_MAX;
               else max_steps_ff <= csr_wdata[MAX_STEPS_W-1:0];
            end
            CSR_PAUSED: begin
               paused_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.add) begin
         acc_in = acc_ff + ACC_W'(scaled);
      end else if (cmd.sub) begin
         acc_in = acc_ff - ACC_W'(fixed_step_ff);
      end else if (cmd.clamp) begin
         acc_in = '0;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pending_ff   <= 1'b0;
         real_sum_ff  <= '0;
         game_sum_ff  <= '0;
         tick_ff      <= '0;
         clamp_cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         if (cmd.apply) begin
            case (op_ff)
               OP_FRAME: begin
                  real_sum_ff <= real_sum_ff + SUM_W'(delta_ff);
                  if (paused_ff && pending_ff) pending_ff <= 1'b0;
               end
               OP_SINGLE: begin
                  pending_ff <= 1'b1;
               end
               OP_CONSUMED: begin
                  game_sum_ff <= game_sum_ff + SUM_W'(fixed_step_ff);
                  tick_ff     <= tick_ff + 1'b1;
               end
               default: begin
               end
            endcase
         end
         if (cmd.clamp) clamp_cnt_ff <= clamp_cnt_ff + 1'b1;
      end
   end

   // working registers and alpha division, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_payload.op;
         delta_ff   <= req_payload.frame_delta;
         steps_ff   <= '0;
         clamped_ff <= 1'b0;
      end
      if (cmd.apply) begin
         product_ff <= PRODUCT_W'(delta_ff) * PRODUCT_W'(time_scale_ff);
         if ((op_ff == OP_FRAME) && paused_ff && pending_ff) steps_ff <= MAX_STEPS_W'(1);
      end
      if (cmd.sub) steps_ff <= steps_ff + 1'b1;
      if (cmd.clamp) clamped_ff <= 1'b1;
      if (cmd.div_init) begin
         rem_ff  <= acc_ff[FIXED_STEP_W-1:0];
         quot_ff <= status.acc_ge_step ? '1 : '0;
      end
      if (cmd.div_step) begin
         if (rem_ge) rem_ff <= FIXED_STEP_W'(rem_dbl - {1'b0, fixed_step_ff});
         else        rem_ff <= rem_dbl[FIXED_STEP_W-1:0];
         quot_ff <= {quot_ff[ALPHA_BITS-2:0], rem_ge};
      end
      if (cmd.load_out) begin
         out_ff.step_count  <= steps_ff;
         out_ff.clamped     <= clamped_ff;
         out_ff.alpha       <= quot_ff;
         out_ff.real_time   <= real_sum_ff;
         out_ff.game_time   <= game_sum_ff;
         out_ff.tick_total  <= tick_ff;
         out_ff.clamp_total <= clamp_cnt_ff;
      end
   end

   assign rsp_payload = out_ff;

endmodule

FILE: rtl/core/fixed_timestep_accumulator.sv
// top level of the fixed timestep accumulator
//
// Takes one request at a time: a frame with its real elapsed time (Q12.20), a
// single-step request, or a step-consumed event, and returns one result for
// each with the steps to run, a clamp flag, the interpolation fraction alpha
// (Q0.16, saturated) and the running totals. A request that does not run the
// timeline goes from acceptance to result through these steps: apply it, set
// up the divider, form the 16 alpha bits and load the output register. A
// running frame adds the scaled add, the removal of each fixed step it takes
// out, at most 60, and the exit from the step loop. When the accumulator
// already holds a whole step (only possible on a request that does not run
// the timeline, after the step was shortened) alpha saturates and the
// division is skipped. The step loop uses a subtractor that removes one
// fixed step per cycle, and alpha comes from a restoring divider that forms
// one bit per cycle. The next request can be taken in the cycle after the
// result is loaded. The result sits in an output register, so the next
// request is taken while it waits; a second result then holds the block until
// the first is taken. Registers are to be written through the csr port only
// while no request is in flight; the block itself does not enforce it. Out of
// range values saturate to the legal range, and no state needs clearing after
// reset.
module fixed_timestep_accumulator
   import fta_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   // register write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // commands down to the datapath, status back to the sequencer
   cmd_type    cmd;
   status_type status;

   // sequencer: accept, scale, step removal, alpha division, hand-off
   fta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, accumulator, totals, divider and output register
   fta_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule
